/* rtl/sct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sketch counter table
// Word layouts, command codes, controller/datapath handshake structs and
// the counter width mask helper.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int unsigned DATA_W       = 32;
   localparam int unsigned HASH_W       = 32;
   localparam int unsigned HASH_ROWS    = 4;
   localparam int unsigned CMD_W        = 3;
   localparam int unsigned CSR_W        = 6;
   localparam int unsigned REDUCE_STEPS = 3;
   localparam int unsigned STEP_W       = $clog2(REDUCE_STEPS);

   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RAISE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ASSIGN = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [DATA_W-1:0] operand;
      logic [HASH_W-1:0] hash_row0;
      logic [HASH_W-1:0] hash_row1;
      logic [HASH_W-1:0] hash_row2;
      logic [HASH_W-1:0] hash_row3;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]    min_value;
      logic [HASH_ROWS-1:0] min_rows;
   } rsp_type;

   typedef struct packed {
      logic clear_wr;
      logic item_load;
      logic reduce_step;
      logic mem_read;
      logic execute;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic reduce_last;
      logic rsp_free;
   } ctrl_status_type;

   function automatic logic [DATA_W-1:0] width_mask(input logic [CSR_W-1:0] width);
      logic [CSR_W-1:0]  active;
      logic [DATA_W-1:0] mask;
      active = (width == '0 || width > CSR_W'(DATA_W)) ? CSR_W'(1) : width;
      for (int i = 0; i < DATA_W; i++) begin
         mask[i] = (CSR_W'(i) < active);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

/* rtl/sct_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sct_ctrl: sequencer of the sketch counter table
// Runs the clearing sweep after reset, then steps each word through index
// reduction, bank read, update or minimum, and result hand-off.
// ----------------------------------------------------------------------------
module sct_ctrl import sct_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_REDUCE  = 7'b0000100,
      ST_READ    = 7'b0001000,
      ST_EXECUTE = 7'b0010000,
      ST_RESPOND = 7'b0100000,
      ST_SPARE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.item_load = req_valid;
            if (req_valid) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce_step = 1'b1;
            if (status.reduce_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_EXECUTE;
         end
         ST_EXECUTE: begin
            cmd.execute = 1'b1;
            state_in    = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/sct_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sct_datapath: counter banks and arithmetic of the sketch counter table
// One counter bank per row, a reciprocal-multiply index reducer per row, the
// update unit, the minimum search and the result register.
// ----------------------------------------------------------------------------
module sct_datapath import sct_pkg::*; #(
   parameter int unsigned ROWS  = 4,
   parameter int unsigned CELLS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   input  wire logic [CSR_W-1:0] csr_data,
   input  wire req_type          req_data,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  wire ctrl_cmd_type     cmd,
   output ctrl_status_type       status
);

   localparam int unsigned       ACTIVE    = (ROWS < HASH_ROWS) ? ROWS : HASH_ROWS;
   localparam int unsigned       IDX_W     = $clog2(CELLS);
   localparam int unsigned       PROD_W    = 2 * HASH_W;
   localparam int unsigned       RECIP_SH  = HASH_W - 1 + IDX_W;
   localparam logic [HASH_W-1:0] RECIP     = HASH_W'((64'd1 << RECIP_SH) / CELLS);
   localparam logic [IDX_W:0]    CELLS_V   = (IDX_W+1)'(CELLS);
   localparam logic [IDX_W-1:0]  LAST_CELL = IDX_W'(CELLS - 1);

   logic [DATA_W-1:0] mask_ff;
   logic [CMD_W-1:0]  op_code_ff;
   logic [DATA_W-1:0] operand_ff;
   logic [STEP_W-1:0] step_ff;
   logic [IDX_W-1:0]  clr_addr_ff;
   logic [DATA_W-1:0] min_ff, min_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              wr_en;

   logic [HASH_W-1:0] req_hash   [HASH_ROWS];
   logic [HASH_W-1:0] hash_ff    [ACTIVE];
   logic [PROD_W-1:0] prod_ff    [ACTIVE];
   logic [IDX_W:0]    est_ff     [ACTIVE];
   logic [IDX_W:0]    est_in     [ACTIVE];
   logic [IDX_W-1:0]  rem_ff     [ACTIVE];
   logic [IDX_W-1:0]  rem_in     [ACTIVE];
   logic [DATA_W-1:0] rdata_ff   [ACTIVE];
   logic [DATA_W-1:0] value      [ACTIVE];
   logic [DATA_W-1:0] next_value [ACTIVE];

   assign req_hash[0] = req_data.hash_row0;
   assign req_hash[1] = req_data.hash_row1;
   assign req_hash[2] = req_data.hash_row2;
   assign req_hash[3] = req_data.hash_row3;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '1;
      end else if (csr_valid) begin
         mask_ff <= width_mask(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         op_code_ff <= req_data.command;
         operand_ff <= req_data.operand & mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= '0;
         clr_addr_ff <= '0;
      end else begin
         if (cmd.item_load) begin
            step_ff <= '0;
         end else if (cmd.reduce_step) begin
            step_ff <= step_ff + 1'b1;
         end
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      case (op_code_ff)
         CMD_ADD, CMD_SUB, CMD_RAISE, CMD_ASSIGN: wr_en = cmd.execute;
         default:                                 wr_en = 1'b0;
      endcase
   end

   for (genvar g = 0; g < ACTIVE; g++) begin : g_row
      logic [DATA_W-1:0] bank_mem [CELLS];
      logic [IDX_W-1:0]  wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              wr;
      logic [IDX_W:0]    est_less;

      // quotient estimate is low by at most one, leaving one subtract of CELLS
      assign est_in[g] = hash_ff[g][IDX_W:0] - prod_ff[g][RECIP_SH +: (IDX_W+1)] * CELLS_V;
      assign est_less  = est_ff[g] - CELLS_V;
      assign rem_in[g] = (est_ff[g] >= CELLS_V) ? est_less[IDX_W-1:0] : est_ff[g][IDX_W-1:0];

      always_ff @(posedge clock) begin
         if (cmd.item_load) begin
            hash_ff[g] <= req_hash[g];
         end
         if (cmd.reduce_step) begin
            prod_ff[g] <= PROD_W'(hash_ff[g]) * PROD_W'(RECIP);
            est_ff[g]  <= est_in[g];
            rem_ff[g]  <= rem_in[g];
         end
      end

      assign value[g] = rdata_ff[g] & mask_ff;

      always_comb begin
         case (op_code_ff)
            CMD_ADD:    next_value[g] = (value[g] + operand_ff) & mask_ff;
            CMD_SUB:    next_value[g] = (value[g] - operand_ff) & mask_ff;
            CMD_RAISE:  next_value[g] = (value[g] < operand_ff) ? operand_ff : value[g];
            CMD_ASSIGN: next_value[g] = operand_ff;
            default:    next_value[g] = value[g];
         endcase
      end

      assign wr      = cmd.clear_wr | wr_en;
      assign wr_addr = cmd.clear_wr ? clr_addr_ff : rem_ff[g];
      assign wr_data = cmd.clear_wr ? '0 : next_value[g];

      always_ff @(posedge clock) begin
         if (wr) begin
            bank_mem[wr_addr] <= wr_data;
         end
         if (cmd.mem_read) begin
            rdata_ff[g] <= bank_mem[rem_ff[g]];
         end
      end
   end

   always_comb begin
      min_in = value[0];
      for (int r = 1; r < ACTIVE; r++) begin
         if (value[r] < min_in) begin
            min_in = value[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         min_ff <= min_in;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (op_code_ff == CMD_QUERY) begin
         rsp_in.min_value = min_ff;
         for (int r = 0; r < ACTIVE; r++) begin
            rsp_in.min_rows[r] = (value[r] == min_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;
   assign status.rsp_free    = ~rsp_valid_ff | rsp_ready;
   assign status.clear_last  = (clr_addr_ff == LAST_CELL);
   assign status.reduce_last = (step_ff == STEP_W'(REDUCE_STEPS - 1));

endmodule

`default_nettype wire

/* rtl/sketch_counter_table_unit.sv */
`default_nettype none
// Each accepted request word runs through the 3-step index reducer (multiply,
// subtract, correct), bank read and update or minimum, and then its response
// word is registered. The next request word is taken only once the last one's
// response is loaded, so a response word left waiting holds the next one back.
// Reset: synchronous; clears all counters by a sweep over all CELLS cells, one
// cell of every row per cycle, before the first request word is taken.
// ----------------------------------------------------------------------------
// sketch_counter_table_unit: count-min sketch counter table
// Rows of wrapping counters addressed by per-row hashes, with add, subtract,
// raise, assign and minimum query commands.
// ----------------------------------------------------------------------------
module sketch_counter_table_unit import sct_pkg::*; #(
   parameter int unsigned ROWS  = 4,
   parameter int unsigned CELLS = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CSR_W-1:0] csr_data,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   sct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sct_datapath #(
      .ROWS  (ROWS),
      .CELLS (CELLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire
